@@ hw/rtl/zero_run_length_decoder_assert.svh @@
// Assertion macros used by the checker file of the zero-run decoder.
`ifndef ZERO_RUN_LENGTH_DECODER_ASSERT_SVH
`define ZERO_RUN_LENGTH_DECODER_ASSERT_SVH

// A condition that must be followed by another one on the next edge,
// checked only outside reset.
`define ZRLD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// A condition that must be followed by another one on the next edge,
// checked during reset as well.
`define ZRLD_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/zrld_pkg.sv @@
// Package with the command type and control-byte constants of the zero-run decoder.
`timescale 1ns / 1ps
`default_nettype none
package zrld_pkg;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 6;

    // Control byte fields.
    localparam int CTRL_BOTH_BIT  = 7;
    localparam int CTRL_ZEROS_BIT = 6;

    localparam logic [7:0] CTRL_BOTH      = 8'h80;
    localparam logic [7:0] CTRL_ZEROS     = 8'h40;
    localparam logic [2:0] BOTH_ZERO_MASK = 3'h7;
    localparam logic [3:0] BOTH_LIT_MASK  = 4'hf;
    localparam logic [5:0] COUNT_MASK     = 6'h3f;

    // One unit of work for the back end: a literal byte, or a run of zeros
    // whose length sits in the low bits of value.
    typedef struct packed {
        logic              is_zero_run;
        logic [BYTE_W-1:0] value;
    } cmd_t;

endpackage
`default_nettype wire

@@ hw/rtl/zero_run_length_decoder.sv @@
// A beat's command is registered in the command queue and its output bytes in the output register.
// Throughput: one literal byte per cycle while the output is not stalled; a zero run holds the back end
// until all its zeros are out, and the two-entry command queue stalls the input once it fills.
// Control bytes that emit no zeros produce no command and nothing at the output.
// Reset (synchronous, active low) clears the literal count, the queue and the
// pending zero run, and drops the output valid.
`timescale 1ns / 1ps
`default_nettype none
module zero_run_length_decoder (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata    // [7:0] out_byte
);

    logic           in_beat;
    logic           cmd_valid;
    zrld_pkg::cmd_t cmd;
    logic           q_full;
    logic           q_pop;
    logic           head_valid;
    zrld_pkg::cmd_t head_cmd;

    assign s_axis_tready = !q_full;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    zrld_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_beat   (in_beat),
        .in_byte   (s_axis_tdata),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    zrld_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (cmd_valid),
        .push_cmd   (cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    zrld_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_byte   (m_axis_tdata),
        .out_ready  (m_axis_tready)
    );

endmodule
`default_nettype wire

@@ hw/rtl/zrld_front.sv @@
// Front end: tracks pending literals and turns each literal and each control byte that asks for zeros into a command.
`timescale 1ns / 1ps
`default_nettype none
module zrld_front (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_beat,
    input  wire logic [7:0]  in_byte,
    output logic             cmd_valid,
    output zrld_pkg::cmd_t   cmd
);

    logic [zrld_pkg::COUNT_W-1:0] literals_left_reg;
    logic [zrld_pkg::COUNT_W-1:0] literals_left_next;
    logic [zrld_pkg::COUNT_W-1:0] zeros;
    logic [zrld_pkg::COUNT_W-1:0] arm;
    logic                         in_literal;

    assign in_literal = (literals_left_reg != '0);

    always_comb begin
        zeros = '0;
        arm   = '0;
        if ((in_byte & zrld_pkg::CTRL_BOTH) != 8'h00) begin
            zeros = {3'b000, in_byte[6:4] & zrld_pkg::BOTH_ZERO_MASK};
            arm   = {2'b00, in_byte[3:0] & zrld_pkg::BOTH_LIT_MASK};
        end else if ((in_byte & zrld_pkg::CTRL_ZEROS) != 8'h00) begin
            zeros = in_byte[5:0] & zrld_pkg::COUNT_MASK;
        end else begin
            arm = in_byte[5:0] & zrld_pkg::COUNT_MASK;
        end
    end

    // A control byte that asks for no zeros only arms the literal count.
    always_comb begin
        literals_left_next = literals_left_reg;
        cmd_valid          = 1'b0;
        cmd.is_zero_run    = 1'b0;
        cmd.value          = in_byte;
        if (in_literal) begin
            cmd_valid = in_beat;
            if (in_beat) begin
                literals_left_next = literals_left_reg - 1'b1;
            end
        end else begin
            cmd_valid       = in_beat && (zeros != '0);
            cmd.is_zero_run = 1'b1;
            cmd.value       = {2'b00, zeros};
            if (in_beat) begin
                literals_left_next = arm;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            literals_left_reg <= '0;
        end else begin
            literals_left_reg <= literals_left_next;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/zrld_queue.sv @@
// Two-entry command queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module zrld_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  zrld_pkg::cmd_t      push_cmd,
    output logic                full,
    input  wire logic           pop,
    output logic                head_valid,
    output zrld_pkg::cmd_t      head_cmd
);

    zrld_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           do_push;
    logic           do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/zrld_back.sv @@
// Back end: plays out literal and zero-run commands into the output register.
`timescale 1ns / 1ps
`default_nettype none
module zrld_back (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        head_valid,
    input  zrld_pkg::cmd_t   head_cmd,
    output logic             pop,
    output logic             out_valid,
    output logic [7:0]       out_byte,
    input  wire logic        out_ready
);

    logic [zrld_pkg::COUNT_W-1:0] zeros_left_reg;
    logic [zrld_pkg::COUNT_W-1:0] zeros_left_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [7:0]                   out_byte_reg;
    logic [7:0]                   out_byte_next;
    logic                         load;

    assign load      = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

    always_comb begin
        zeros_left_next = zeros_left_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_byte_next   = out_byte_reg;
        pop             = 1'b0;
        if (load) begin
            if (zeros_left_reg != '0) begin
                out_valid_next  = 1'b1;
                out_byte_next   = 8'h00;
                zeros_left_next = zeros_left_reg - 1'b1;
            end else if (head_valid) begin
                pop            = 1'b1;
                out_valid_next = 1'b1;
                if (head_cmd.is_zero_run) begin
                    // Runs are never empty; the first zero goes out now.
                    out_byte_next   = 8'h00;
                    zeros_left_next = head_cmd.value[zrld_pkg::COUNT_W-1:0] - 1'b1;
                end else begin
                    out_byte_next = head_cmd.value;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg <= out_byte_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zeros_left_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            zeros_left_reg <= zeros_left_next;
            out_valid_reg  <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/zrld_checker.sv @@
// Port-level checker for the zero-run decoder and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "zero_run_length_decoder_assert.svh"
module zrld_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic [7:0] s_axis_tdata,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata
);

    logic s_idle;

    assign s_idle = !s_axis_tvalid && s_axis_tdata == s_axis_tdata;

    // A stalled output beat stays offered with the same byte.
    `ZRLD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output beat dropped while stalled")
    `ZRLD_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "output byte changed while stalled")
    // Reset leaves no output pending and, with the input idle, the input ready.
    `ZRLD_ASSERT_ALWAYS(a_reset_out, aclk, !aresetn, !m_axis_tvalid, "output valid after reset")
    `ZRLD_ASSERT_ALWAYS(a_reset_in, aclk, !aresetn && s_idle, s_axis_tready, "input not ready after reset")

endmodule

bind zero_run_length_decoder zrld_checker u_zrld_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

@@ tb/tb_zero_run_length_decoder.sv @@
// Self-checking testbench for the zero-run decoder: directed bytes, then random streams with stalls on both sides.
`timescale 1ns / 1ps

module tb_zero_run_length_decoder;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 90;
    localparam int CALM_TAIL    = 25;

    // Tracks the literal count the decoder should hold and the bytes it still owes.
    class zero_run_scoreboard;
        logic [zrld_pkg::COUNT_W-1:0] literals_left;
        logic [zrld_pkg::BYTE_W-1:0]  owed_bytes[$];
        int                           errors;

        function new();
            literals_left = '0;
            errors        = 0;
        endfunction

        function void note_input(logic [zrld_pkg::BYTE_W-1:0] b);
            int zeros;
            zeros = 0;
            if (literals_left != 0) begin
                owed_bytes.push_back(b);
                literals_left = literals_left - 1'b1;
                return;
            end
            if (b[zrld_pkg::CTRL_BOTH_BIT]) begin
                zeros         = int'(b[6:4] & zrld_pkg::BOTH_ZERO_MASK);
                literals_left = {2'b00, b[3:0] & zrld_pkg::BOTH_LIT_MASK};
            end else if (b[zrld_pkg::CTRL_ZEROS_BIT]) begin
                zeros         = int'(b[5:0] & zrld_pkg::COUNT_MASK);
                literals_left = '0;
            end else begin
                literals_left = b[5:0] & zrld_pkg::COUNT_MASK;
            end
            repeat (zeros) owed_bytes.push_back(8'h00);
        endfunction

        function void check_result(logic [zrld_pkg::BYTE_W-1:0] got);
            logic [zrld_pkg::BYTE_W-1:0] want;
            if (owed_bytes.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected output beat: out_byte=%02h", got);
                return;
            end
            want = owed_bytes.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("out_byte mismatch: expected %02h, actual %02h", want, got);
            end
        endfunction

        function int pending();
            return owed_bytes.size();
        endfunction
    endclass

    logic       aclk;
    logic       aresetn       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;

    zero_run_scoreboard decoded_sb = new();
    bit  idle_off = 1'b0;
    int  sink_stall = 0;
    int  cycle_count = 0;
    int  random_sent = 0;

    zero_run_length_decoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_zero_run_length_decoder: errors");
            $finish;
        end
    end

    // Output side: check every accepted beat, then pick the next ready value.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            decoded_sb.check_result(m_axis_tdata);
        if (sink_stall > 0) begin
            sink_stall--;
            m_axis_tready <= 1'b0;
        end else if (!idle_off && $urandom_range(0, 7) == 0) begin
            sink_stall = $urandom_range(1, 13) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (!idle_off && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge aclk); while (!s_axis_tready);
        decoded_sb.note_input(b);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (decoded_sb.pending() != 0);
    endtask

    // One control byte followed by the literals it arms; the literal count
    // is derived from the control byte itself.
    task automatic send_sequence(input logic [7:0] ctrl);
        int lits;
        if (ctrl[zrld_pkg::CTRL_BOTH_BIT])
            lits = int'(ctrl[3:0]);
        else if (ctrl[zrld_pkg::CTRL_ZEROS_BIT])
            lits = 0;
        else
            lits = int'(ctrl[5:0]);
        send_byte(ctrl);
        random_sent++;
        repeat (lits) begin
            send_byte(8'($urandom_range(0, 255)));
            random_sent++;
        end
    endtask

    initial begin
        logic [7:0] directed[$];
        logic [7:0] ctrl;
        int         pick;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty controls, the longest zero runs, a mixed run with literals that
        // look like control bytes, and plain literal runs.
        directed = '{8'h00, 8'h40, 8'h80, 8'h7F, 8'h41, 8'hF0,
                     8'hF2, 8'hFF, 8'h00,
                     8'h02, 8'h40, 8'h7F,
                     8'h81, 8'h80,
                     8'h01, 8'h55};
        foreach (directed[i]) send_byte(directed[i]);

        // Let the decoder drain completely before the random part starts.
        wait_drained();

        // A control byte that only arms fifteen literals.
        send_sequence(8'h8F);

        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent >= RANDOM_ITEMS - CALM_TAIL)
                idle_off = 1'b1;
            else
                idle_off = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 3);
            case (pick)
                0: ctrl = zrld_pkg::CTRL_BOTH | 8'($urandom_range(0, 127));
                1: ctrl = zrld_pkg::CTRL_ZEROS | 8'($urandom_range(0, 63));
                2: begin
                    if ($urandom_range(0, 5) == 0)
                        ctrl = 8'($urandom_range(0, 63));
                    else
                        ctrl = 8'($urandom_range(0, 7));
                end
                default: ctrl = 8'($urandom_range(0, 255));
            endcase
            send_sequence(ctrl);
            if (!idle_off && $urandom_range(0, 9) == 0)
                wait_drained();
        end

        idle_off = 1'b1;
        wait_drained();
        repeat (10) @(posedge aclk);

        if (decoded_sb.errors == 0 && decoded_sb.pending() == 0) begin
            $display("tb_zero_run_length_decoder: clean");
        end else begin
            $display("tb_zero_run_length_decoder: errors");
        end
        $finish;
    end
endmodule
